FILE: src/phrc_pkg.sv
// ----------------------------------------------------------------------------
// phrc_pkg
// Shared types and constants of the position hash and repetition check.
// ----------------------------------------------------------------------------
`default_nettype none

package phrc_pkg;

	localparam int HISTORY_DEPTH = 256;
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int OCC_W         = 9;
	localparam int HASH_W        = 64;
	localparam int IDX_W         = 4;
	localparam int CR_W          = 4;
	localparam int EP_W          = 7;
	localparam int KEY_N         = 1 << IDX_W;

	localparam logic [HASH_W-1:0] KEY_BASE   = 64'h9E3779B97F4A7C15;
	localparam logic [HASH_W-1:0] KEY_STEP   = 64'h517CC1B727220A95;
	localparam logic [HASH_W-1:0] KEY_CASTLE = 64'h6C62272E07BB0142;
	localparam logic [HASH_W-1:0] KEY_EP     = 64'hBF58476D1CE4E5B9;
	localparam logic [HASH_W-1:0] KEY_BLACK  = 64'h94D049BB133111EB;
	localparam logic [HASH_W-1:0] FIN_MUL1   = 64'hBF58476D1CE4E5B9;
	localparam logic [HASH_W-1:0] FIN_MUL2   = 64'h94D049BB133111EB;
	localparam logic [OCC_W-1:0]  OCC_MAX    = '1;
	localparam logic [OCC_W-1:0]  REPEAT_RST = OCC_W'(3);

	typedef logic [HASH_W-1:0] key_tbl_t [KEY_N];

	// per board index multiplier, built at elaboration
	function automatic key_tbl_t gen_keys();
		key_tbl_t t;
		logic [HASH_W-1:0] k;
		k = KEY_BASE;
		for (int i = 0; i < KEY_N; i++) begin
			t[i] = k;
			k    = k + KEY_STEP;
		end
		return t;
	endfunction

	localparam key_tbl_t KEY_TBL = gen_keys();

	// multiplier request / response
	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] a;
		logic [HASH_W-1:0] b;
	} phrc_mreq_t;

	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] p;
	} phrc_mrsp_t;

	// finished position hash from the hash engine
	typedef struct packed {
		logic              vld;
		logic              clr;
		logic [HASH_W-1:0] hash;
	} phrc_hres_t;

	// compare token walking down the history cells
	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] rem;
		logic [OCC_W-1:0] occ;
	} phrc_tok_t;

endpackage

`default_nettype wire

FILE: src/phrc_mul.sv
// ----------------------------------------------------------------------------
// phrc_mul
// 64x64 multiplier, low half of the product, built from three passes
// through one 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module phrc_mul
	import phrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire phrc_mreq_t req,
	output phrc_mrsp_t      rsp
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_P0,
		M_P1,
		M_P2,
		M_DONE
	} mstate_t;

	mstate_t           state_q;
	logic [63:0]       a_q;
	logic [63:0]       b_q;
	logic [63:0]       p0_q;
	logic [31:0]       x_q;
	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [63:0]       mo;

	always_comb begin
		case (state_q)
			M_P0: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
			M_P1: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			default: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
		endcase
	end

	assign mo = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			p0_q    <= '0;
			x_q     <= '0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						state_q <= M_P0;
					end
				end
				M_P0: begin
					p0_q    <= mo;
					state_q <= M_P1;
				end
				M_P1: begin
					x_q     <= mo[31:0];
					state_q <= M_P2;
				end
				M_P2: begin
					x_q     <= x_q + mo[31:0];
					state_q <= M_DONE;
				end
				M_DONE: begin
					// a new request may follow the result directly
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						state_q <= M_P0;
					end else begin
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == M_DONE);
	assign rsp.p    = p0_q + {x_q, 32'b0};

endmodule

`default_nettype wire

FILE: src/phrc_hash.sv
// ----------------------------------------------------------------------------
// phrc_hash
// Bitboard accumulator and hash finalizer, all multiplies through one
// shared iterative multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module phrc_hash
	import phrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [HASH_W-1:0] bitboard,
	input  wire logic [IDX_W-1:0]  board_index,
	input  wire logic              last_board,
	input  wire logic [CR_W-1:0]   castle_bits,
	input  wire logic [EP_W-1:0]   en_passant_square,
	input  wire logic              black_to_move,
	input  wire logic              clear_history,
	output logic                   busy,
	output phrc_hres_t             hres
);

	typedef enum logic [2:0] {
		H_IDLE,
		H_BB,
		H_CR,
		H_EP,
		H_F1,
		H_F2
	} hstate_t;

	hstate_t           state_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] h_q;
	logic              last_q;
	logic [CR_W-1:0]   cr_q;
	logic [EP_W-1:0]   ep_q;
	logic              black_q;
	logic              clr_q;
	phrc_hres_t        hres_q;

	phrc_mreq_t        mreq;
	phrc_mrsp_t        mrsp;

	logic [HASH_W-1:0] acc_nxt;
	logic [HASH_W-1:0] pre_fin;
	logic [HASH_W-1:0] fin1_in;
	logic [HASH_W-1:0] fin2_in;

	assign acc_nxt = acc_q ^ mrsp.p;
	assign pre_fin = h_q ^ mrsp.p;
	assign fin1_in = pre_fin ^ (pre_fin >> 30);
	assign fin2_in = mrsp.p ^ (mrsp.p >> 27);

	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = bitboard;
		mreq.b     = KEY_TBL[board_index];
		case (state_q)
			H_IDLE: begin
				mreq.start = start;
			end
			H_BB: begin
				mreq.start = mrsp.done && last_q;
				mreq.a     = {{(HASH_W-CR_W){1'b0}}, cr_q};
				mreq.b     = KEY_CASTLE;
			end
			H_CR: begin
				mreq.start = mrsp.done;
				mreq.a     = {{(HASH_W-EP_W){1'b0}}, ep_q};
				mreq.b     = KEY_EP;
			end
			H_EP: begin
				mreq.start = mrsp.done;
				mreq.a     = fin1_in;
				mreq.b     = FIN_MUL1;
			end
			H_F1: begin
				mreq.start = mrsp.done;
				mreq.a     = fin2_in;
				mreq.b     = FIN_MUL2;
			end
			default: begin
				mreq.start = 1'b0;
			end
		endcase
	end

	phrc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			acc_q   <= '0;
			h_q     <= '0;
			last_q  <= 1'b0;
			cr_q    <= '0;
			ep_q    <= '0;
			black_q <= 1'b0;
			clr_q   <= 1'b0;
			hres_q  <= '0;
		end else begin
			hres_q.vld <= (state_q == H_F2) && mrsp.done;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						last_q  <= last_board;
						cr_q    <= castle_bits;
						ep_q    <= en_passant_square;
						black_q <= black_to_move;
						clr_q   <= clear_history;
						state_q <= H_BB;
					end
				end
				H_BB: begin
					if (mrsp.done) begin
						if (last_q) begin
							h_q     <= acc_nxt ^ (black_q ? KEY_BLACK : '0);
							acc_q   <= '0;
							state_q <= H_CR;
						end else begin
							acc_q   <= acc_nxt;
							state_q <= H_IDLE;
						end
					end
				end
				H_CR: begin
					if (mrsp.done) begin
						h_q     <= pre_fin;
						state_q <= H_EP;
					end
				end
				H_EP: begin
					if (mrsp.done) begin
						state_q <= H_F1;
					end
				end
				H_F1: begin
					if (mrsp.done) begin
						state_q <= H_F2;
					end
				end
				H_F2: begin
					if (mrsp.done) begin
						hres_q.clr  <= clr_q;
						hres_q.hash <= mrsp.p ^ (mrsp.p >> 31);
						state_q     <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign busy = (state_q != H_IDLE) || hres_q.vld;
	assign hres = hres_q;

endmodule

`default_nettype wire

FILE: src/phrc_cell.sv
// ----------------------------------------------------------------------------
// phrc_cell
// One history entry: holds a stored hash, shifts it on to the next cell on
// a store, and counts a match into the passing compare token.
// ----------------------------------------------------------------------------
`default_nettype none

module phrc_cell
	import phrc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift_en,
	input  wire logic [HASH_W-1:0] ent_i,
	input  wire logic [HASH_W-1:0] hash,
	input  wire phrc_tok_t         tok_i,
	output logic [HASH_W-1:0]      ent_o,
	output phrc_tok_t              tok_o
);

	logic [HASH_W-1:0] entry_q;
	logic              tok_vld_q;
	logic [CNT_W-1:0]  tok_rem_q;
	logic [OCC_W-1:0]  tok_occ_q;
	logic              live;
	logic              hit;

	// rem counts the occupied cells still ahead of the token
	assign live = (tok_i.rem != '0);
	assign hit  = live && (entry_q == hash) && (tok_i.occ != OCC_MAX);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= ent_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_rem_q <= live ? tok_i.rem - CNT_W'(1) : tok_i.rem;
		tok_occ_q <= hit ? tok_i.occ + OCC_W'(1) : tok_i.occ;
	end

	assign ent_o     = entry_q;
	assign tok_o.vld = tok_vld_q;
	assign tok_o.rem = tok_rem_q;
	assign tok_o.occ = tok_occ_q;

endmodule

`default_nettype wire

FILE: src/position_hash_repetition_check.sv
// ----------------------------------------------------------------------------
// position_hash_repetition_check
// Hashes a position given as piece bitboards, keeps a history of position
// hashes in a row of cells and reports how often the new hash occurs.
// ----------------------------------------------------------------------------
//
// channel  dir  content
// s_*      in   one bitboard beat, tlast marks the last bitboard of a position
// m_*      out  hash, occurrence count, repeated and history full flags
// repeat_* in   repeat_count register write
//
// A bitboard beat costs one 64-bit multiply, done as three passes of a
// shared 32x32 multiplier plus the product add. The last beat of a position
// adds 4 more multiplies for the castling, en passant and finalizer terms,
// and then the compare token walks the cell row. A spare result register
// lets one result wait unread. Every beat waits while the hash engine or a
// search is busy, and a last beat also waits while two results are
// unread.
// Reset clears the history count; the cell contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module position_hash_repetition_check
	import phrc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// bitboard[63:0], castle_bits[67:64], en_passant_square[74:68],
	// black_to_move[75], clear_history[76], zero[79:77]
	input  wire logic [79:0]  s_tdata,
	// board_index[3:0]
	input  wire logic [3:0]   s_tuser,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// position_hash[63:0], occurrences[72:64], repeated[73],
	// history_full[74], zero[79:75]
	output logic [79:0]       m_tdata,
	input  wire logic         repeat_count_wr_en,
	input  wire logic [8:0]   repeat_count_wr_data
);

	logic              s_beat;
	logic              hash_busy;
	phrc_hres_t        hres;

	logic [CNT_W-1:0]  stored_q;
	logic              search_q;
	logic [OCC_W-1:0]  rcnt_q;
	logic              m_tvalid_q;
	logic [HASH_W-1:0] out_hash_q;
	logic [OCC_W-1:0]  out_occ_q;
	logic              out_rep_q;
	logic              out_full_q;
	logic              spare_vld_q;
	logic [HASH_W-1:0] spare_hash_q;
	logic [OCC_W-1:0]  spare_occ_q;
	logic              spare_rep_q;
	logic              spare_full_q;

	phrc_tok_t         tok [HISTORY_DEPTH+1];
	logic [HASH_W-1:0] ent [HISTORY_DEPTH+1];
	logic              done;
	logic              full;
	logic              shift_en;
	logic              out_free;
	logic              m_beat;
	phrc_tok_t         tok_exit;

	assign s_tready = !hash_busy && !search_q && (!s_tlast || !spare_vld_q);
	assign s_beat   = s_tvalid && s_tready;

	phrc_hash u_hash (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (s_beat),
		.bitboard          (s_tdata[63:0]),
		.board_index       (s_tuser),
		.last_board        (s_tlast),
		.castle_bits       (s_tdata[67:64]),
		.en_passant_square (s_tdata[74:68]),
		.black_to_move     (s_tdata[75]),
		.clear_history     (s_tdata[76]),
		.busy              (hash_busy),
		.hres              (hres)
	);

	// token enters the newest cell; history is newest first
	assign tok[0].vld = hres.vld;
	assign tok[0].rem = hres.clr ? '0 : stored_q;
	assign tok[0].occ = OCC_W'(1);
	assign ent[0]     = hres.hash;

	assign tok_exit = tok[HISTORY_DEPTH];
	assign done     = tok_exit.vld;
	assign full     = (stored_q >= CNT_W'(HISTORY_DEPTH));
	assign shift_en = done && !full;

	// a new result goes to the output register when it is empty or being read
	assign m_beat   = m_tvalid_q && m_tready;
	assign out_free = !m_tvalid_q || m_tready;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		phrc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.ent_i    (ent[i]),
			.hash     (hres.hash),
			.tok_i    (tok[i]),
			.ent_o    (ent[i+1]),
			.tok_o    (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q    <= '0;
			search_q    <= 1'b0;
			rcnt_q      <= REPEAT_RST;
			m_tvalid_q  <= 1'b0;
			spare_vld_q <= 1'b0;
		end else begin
			if (repeat_count_wr_en) begin
				rcnt_q <= repeat_count_wr_data;
			end
			if (hres.vld) begin
				search_q <= 1'b1;
				if (hres.clr) begin
					stored_q <= '0;
				end
			end
			if (done) begin
				search_q <= 1'b0;
				if (!full) begin
					stored_q <= stored_q + CNT_W'(1);
				end
			end
			if (done) begin
				if (out_free) begin
					m_tvalid_q <= 1'b1;
				end else begin
					spare_vld_q <= 1'b1;
				end
			end else if (m_beat) begin
				if (spare_vld_q) begin
					spare_vld_q <= 1'b0;
				end else begin
					m_tvalid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (out_free) begin
				out_hash_q <= hres.hash;
				out_occ_q  <= tok_exit.occ;
				out_rep_q  <= (tok_exit.occ >= rcnt_q);
				out_full_q <= full;
			end else begin
				spare_hash_q <= hres.hash;
				spare_occ_q  <= tok_exit.occ;
				spare_rep_q  <= (tok_exit.occ >= rcnt_q);
				spare_full_q <= full;
			end
		end else if (m_beat && spare_vld_q) begin
			out_hash_q <= spare_hash_q;
			out_occ_q  <= spare_occ_q;
			out_rep_q  <= spare_rep_q;
			out_full_q <= spare_full_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_full_q, out_rep_q, out_occ_q, out_hash_q};

endmodule

`default_nettype wire
